### rtl/core/sprite_line_evaluator_macros.svh
// assertion macros for the sprite line evaluator
`ifndef SPRITE_LINE_EVALUATOR_MACROS_SVH
`define SPRITE_LINE_EVALUATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite line evaluator check failed");

// next-cycle implication, sampled on clk, off during rst
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite line evaluator check failed");

`endif

### rtl/core/sle_pkg.sv
// types, constants and tables shared by the sprite line evaluator
`timescale 1ns / 1ps
package sle_pkg;

  localparam int TableEntries = 128;
  localparam int EntryW       = 7;
  localparam int AddrW        = $clog2(TableEntries);

  localparam int StepsWide    = 80;
  localparam int StepsNarrow  = 64;
  localparam int HitLimitWide = 20;
  localparam int HitLimitNarrow = 16;

  typedef logic [EntryW:0] entry_cnt_t;

  localparam logic [1:0] ActWriteA = 2'd0;
  localparam logic [1:0] ActWriteB = 2'd1;
  localparam logic [1:0] ActEval   = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t CfgWideMode  = 1'd0;
  localparam cfg_index_t CfgInterlace = 1'd1;

  // sprite height by size code
  localparam logic [5:0] HeightOfCode [4] = '{6'd8, 6'd16, 6'd24, 6'd32};

  typedef struct packed {
    logic [1:0]        action;
    logic [EntryW-1:0] entry;
    logic [15:0]       y_word;
    logic [7:0]        size_byte;
    logic [EntryW-1:0] next_link;
    logic [15:0]       x_word;
    logic [15:0]       attr_word;
    logic [8:0]        scanline;
    logic              vint_flag;
  } cmd_item_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  slot;
    logic [6:0]  walk_step;
    logic [15:0] hit_y_word;
    logic [15:0] hit_x_word;
    logic [15:0] hit_attr_word;
    logic [7:0]  hit_size_byte;
    logic        overflow;
    logic        last;
  } res_item_t;

  typedef struct packed {
    logic [15:0]       y_word;
    logic [7:0]        size_byte;
    logic [EntryW-1:0] next_link;
    logic [15:0]       x_word;
    logic [15:0]       attr_word;
  } sprite_entry_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic [EntryW-1:0] wr_addr;
    sprite_entry_t     wr_entry;
    logic              rd_en;
    logic [EntryW-1:0] rd_addr;
  } tbl_req_t;

endpackage

### rtl/core/sle_cmd_if.sv
// command channel: valid, ready and one input item
`timescale 1ns / 1ps
interface sle_cmd_if;
  import sle_pkg::*;

  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sle_res_if.sv
// result channel: valid, ready and one result item
`timescale 1ns / 1ps
interface sle_res_if;
  import sle_pkg::*;

  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/sle_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module sle_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/sle_table.sv
// sprite attribute table: two rams plus per-entry valid bits for the zero reset
`timescale 1ns / 1ps
module sle_table (
  input  logic                  clk,
  input  logic                  rst,
  input  sle_pkg::tbl_req_t     req,
  output sle_pkg::sprite_entry_t rd_entry
);
  import sle_pkg::*;

  localparam int WidthA = 16 + 8 + EntryW;
  localparam int WidthB = 32;

  logic [TableEntries-1:0] va_a;
  logic [TableEntries-1:0] va_b;
  logic                    wr_ok;
  logic                    rd_ok;
  logic                    rd_va_a;
  logic                    rd_va_b;
  logic [AddrW-1:0]        wr_idx;
  logic [AddrW-1:0]        rd_idx;
  logic [WidthA-1:0]       rd_a;
  logic [WidthB-1:0]       rd_b;

  assign wr_idx = req.wr_addr[AddrW-1:0];
  assign rd_idx = req.rd_addr[AddrW-1:0];
  assign wr_ok  = entry_cnt_t'(req.wr_addr) < entry_cnt_t'(TableEntries);
  assign rd_ok  = entry_cnt_t'(req.rd_addr) < entry_cnt_t'(TableEntries);

  sle_ram #(.Width(WidthA), .Depth(TableEntries)) u_ram_a (
    .clk     (clk),
    .wr_en   (req.wr_a && wr_ok),
    .wr_addr (wr_idx),
    .wr_data ({req.wr_entry.y_word, req.wr_entry.size_byte, req.wr_entry.next_link}),
    .rd_en   (req.rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_a)
  );

  sle_ram #(.Width(WidthB), .Depth(TableEntries)) u_ram_b (
    .clk     (clk),
    .wr_en   (req.wr_b && wr_ok),
    .wr_addr (wr_idx),
    .wr_data ({req.wr_entry.x_word, req.wr_entry.attr_word}),
    .rd_en   (req.rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va_a    <= '0;
      va_b    <= '0;
      rd_va_a <= 1'b0;
      rd_va_b <= 1'b0;
    end else begin
      if (req.wr_a && wr_ok) begin
        va_a[wr_idx] <= 1'b1;
      end
      if (req.wr_b && wr_ok) begin
        va_b[wr_idx] <= 1'b1;
      end
      // out-of-range and never-written entries read as zero
      if (req.rd_en) begin
        rd_va_a <= rd_ok && va_a[rd_idx];
        rd_va_b <= rd_ok && va_b[rd_idx];
      end
    end
  end

  always_comb begin
    rd_entry = '0;
    if (rd_va_a) begin
      rd_entry.y_word    = rd_a[WidthA-1 -: 16];
      rd_entry.size_byte = rd_a[EntryW +: 8];
      rd_entry.next_link = rd_a[EntryW-1:0];
    end
    if (rd_va_b) begin
      rd_entry.x_word    = rd_b[31:16];
      rd_entry.attr_word = rd_b[15:0];
    end
  end

endmodule

### rtl/core/sle_walker.sv
// command decode, linked-list walk and result buffering
`timescale 1ns / 1ps
module sle_walker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wide_mode,
  input  logic                   interlace_double,
  input  logic                   cmd_valid,
  input  sle_pkg::cmd_item_t     cmd_data,
  output logic                   cmd_ready,
  output logic                   res_valid,
  output sle_pkg::res_item_t     res_data,
  input  logic                   res_ready,
  output sle_pkg::tbl_req_t      tbl_req,
  input  sle_pkg::sprite_entry_t entry
);
  import sle_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_FLUSH} state_t;

  state_t     state;
  logic [8:0] line;
  logic       vint;
  logic [6:0] step;
  logic [4:0] hits;
  res_item_t  pend;
  logic       pv;
  res_item_t  outr;
  logic       ov;

  logic       cmd_take;
  logic [8:0] ypos;
  logic [9:0] ypos_end;
  logic       hit;
  logic [4:0] limit_m1;
  logic [6:0] step_m1;
  logic       limit_reached;
  logic       walk_done;
  logic       out_free;
  logic       stall;
  logic       advance;
  res_item_t  new_hit;
  res_item_t  flush_item;
  res_item_t  no_hit;

  assign cmd_ready = (state == S_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign res_valid = ov;
  assign res_data  = outr;
  assign out_free  = !ov || res_ready;

  assign ypos     = interlace_double ? entry.y_word[9:1] : entry.y_word[8:0];
  assign ypos_end = {1'b0, ypos} + {4'b0, HeightOfCode[entry.size_byte[1:0]]};
  assign hit      = (line >= ypos) && ({1'b0, line} < ypos_end);

  assign limit_m1 = wide_mode ? 5'(HitLimitWide - 1) : 5'(HitLimitNarrow - 1);
  assign step_m1  = wide_mode ? 7'(StepsWide - 1) : 7'(StepsNarrow - 1);

  assign limit_reached = hit && (hits == limit_m1);
  assign walk_done     = limit_reached || (entry.next_link == '0) || (step == step_m1);

  // a new hit pushes the held one out, so it needs a free output slot
  assign stall   = hit && pv && !out_free;
  assign advance = (state == S_EVAL) && !stall;

  always_comb begin
    new_hit               = '0;
    new_hit.found         = 1'b1;
    new_hit.slot          = hits;
    new_hit.walk_step     = step;
    new_hit.hit_y_word    = entry.y_word;
    new_hit.hit_x_word    = entry.x_word;
    new_hit.hit_attr_word = entry.attr_word;
    new_hit.hit_size_byte = entry.size_byte;
    new_hit.overflow      = limit_reached && !vint;
    new_hit.last          = limit_reached;

    flush_item      = pend;
    flush_item.last = 1'b1;

    no_hit      = '0;
    no_hit.last = 1'b1;
  end

  always_comb begin
    tbl_req                    = '0;
    tbl_req.wr_a               = cmd_take && (cmd_data.action == ActWriteA);
    tbl_req.wr_b               = cmd_take && (cmd_data.action == ActWriteB);
    tbl_req.wr_addr            = cmd_data.entry;
    tbl_req.wr_entry.y_word    = cmd_data.y_word;
    tbl_req.wr_entry.size_byte = cmd_data.size_byte;
    tbl_req.wr_entry.next_link = cmd_data.next_link;
    tbl_req.wr_entry.x_word    = cmd_data.x_word;
    tbl_req.wr_entry.attr_word = cmd_data.attr_word;
    tbl_req.rd_en   = (cmd_take && (cmd_data.action == ActEval)) || (advance && !walk_done);
    tbl_req.rd_addr = (state == S_IDLE) ? '0 : entry.next_link;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
      ov    <= 1'b0;
    end else begin
      if (ov && res_ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take && (cmd_data.action == ActEval)) begin
            line  <= cmd_data.scanline;
            vint  <= cmd_data.vint_flag;
            step  <= '0;
            hits  <= '0;
            pv    <= 1'b0;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (advance) begin
            if (hit) begin
              if (pv) begin
                outr <= pend;
                ov   <= 1'b1;
              end
              pend <= new_hit;
              pv   <= 1'b1;
              hits <= hits + 5'd1;
            end
            if (walk_done) begin
              state <= S_FLUSH;
            end else begin
              step <= step + 7'd1;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            outr  <= pv ? flush_item : no_hit;
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/sprite_line_evaluator.sv
// top level: configuration registers, sprite table and list walker
// a write action goes to the table as it transfers in; an evaluate walks one entry per cycle
// while no result stall holds it, and its last result leaves from the flush state
// one item at a time: the input is busy for the whole walk and flush,
// plus result stalls; a hit waits for the next hit or the end of the walk to leave
// reset clears the table at once through per-entry valid bits, no clearing pass
`timescale 1ns / 1ps
`include "sprite_line_evaluator_macros.svh"
module sprite_line_evaluator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  sle_pkg::cfg_index_t cfg_index,
  input  logic                cfg_data,
  sle_cmd_if.sink             cmd,
  sle_res_if.source           res
);
  import sle_pkg::*;

  logic          wide_mode;
  logic          interlace_double;
  tbl_req_t      tbl_req;
  sprite_entry_t rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode        <= 1'b0;
      interlace_double <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgWideMode:  wide_mode        <= cfg_data;
        CfgInterlace: interlace_double <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sle_table u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (tbl_req),
    .rd_entry (rd_entry)
  );

  sle_walker u_walker (
    .clk              (clk),
    .rst              (rst),
    .wide_mode        (wide_mode),
    .interlace_double (interlace_double),
    .cmd_valid        (cmd.valid),
    .cmd_data         (cmd.data),
    .cmd_ready        (cmd.ready),
    .res_valid        (res.valid),
    .res_data         (res.data),
    .res_ready        (res.ready),
    .tbl_req          (tbl_req),
    .entry            (rd_entry)
  );

  `SLE_ASSERT_NEXT(a_eval_busy, cmd.valid && cmd.ready && cmd.data.action == ActEval, !cmd.ready)
  `SLE_ASSERT_NOW(a_nohit_last, res.valid && !res.data.found, res.data.last && res.data.slot == '0 && !res.data.overflow)
  `SLE_ASSERT_NOW(a_ovf_last, res.valid && res.data.overflow, res.data.last && res.data.found)
  `SLE_ASSERT_NOW(a_res_range, res.valid, res.data.walk_step < 7'(StepsWide) && res.data.slot < 5'(HitLimitWide))

endmodule

### test/tb_top.sv
// self-checking testbench for the sprite line evaluator: list walks against a local table copy
`timescale 1ns / 1ps
module tb_top;
  import sle_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  logic       cfg_data;

  sle_cmd_if cmd_ch ();
  sle_res_if res_ch ();

  sprite_line_evaluator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  // local copy of the sprite table and registers
  logic [15:0]       y_tbl   [TableEntries];
  logic [7:0]        sz_tbl  [TableEntries];
  logic [EntryW-1:0] lnk_tbl [TableEntries];
  logic [15:0]       x_tbl   [TableEntries];
  logic [15:0]       attr_tbl[TableEntries];
  logic              cfg_wide;
  logic              cfg_inter;

  cmd_item_t cmd_backlog[$];
  res_item_t sprite_hits_due[$];
  res_item_t hit_want;
  int        cmds_queued;
  int        cmds_taken;
  int        errors;
  int        send_gap;
  int        recv_gap;
  int        recv_hold;
  logic      hold_kick;
  logic      quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // expected results of one scanline evaluation
  task automatic walk_sprite_list(input logic [8:0] line, input logic vint);
    int        lim;
    int        steps;
    int        hits;
    int        cur;
    int        ypos;
    int        ht;
    bit        stop;
    bit        held_ok;
    res_item_t hit;
    res_item_t held;
    lim = cfg_wide ? HitLimitWide : HitLimitNarrow;
    steps = cfg_wide ? StepsWide : StepsNarrow;
    hits = 0;
    cur = 0;
    stop = 1'b0;
    held_ok = 1'b0;
    held = '0;
    for (int s = 0; s < steps && !stop; s++) begin
      ypos = cfg_inter ? int'(y_tbl[cur][9:1]) : int'(y_tbl[cur][8:0]);
      ht = 8 * (int'(sz_tbl[cur][1:0]) + 1);
      if (int'(line) >= ypos && int'(line) < ypos + ht) begin
        hit = '0;
        hit.found = 1'b1;
        hit.slot = hits[4:0];
        hit.walk_step = s[6:0];
        hit.hit_y_word = y_tbl[cur];
        hit.hit_x_word = x_tbl[cur];
        hit.hit_attr_word = attr_tbl[cur];
        hit.hit_size_byte = sz_tbl[cur];
        hits++;
        if (hits == lim) begin
          hit.overflow = ~vint;
          hit.last = 1'b1;
          stop = 1'b1;
        end
        if (held_ok) sprite_hits_due.push_back(held);
        held = hit;
        held_ok = 1'b1;
      end
      if (!stop) begin
        cur = int'(lnk_tbl[cur]);
        if (cur == 0) stop = 1'b1;
      end
    end
    // a line with no hit still gets one empty result
    held.last = 1'b1;
    sprite_hits_due.push_back(held);
  endtask

  task automatic absorb_cmd(input cmd_item_t c);
    case (c.action)
      ActWriteA: begin
        y_tbl[c.entry] = c.y_word;
        sz_tbl[c.entry] = c.size_byte;
        lnk_tbl[c.entry] = c.next_link;
      end
      ActWriteB: begin
        x_tbl[c.entry] = c.x_word;
        attr_tbl[c.entry] = c.attr_word;
      end
      ActEval: walk_sprite_list(c.scanline, c.vint_flag);
      default: ;
    endcase
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        absorb_cmd(cmd_ch.data);
        cmds_taken <= cmds_taken + 1;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap > 0) begin
          cmd_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          cmd_ch.valid <= 1'b0;
          send_gap <= $urandom_range(0, 11);
        end else if (cmd_backlog.size() > 0) begin
          cmd_ch.data <= cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready with short stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
      recv_hold <= 0;
    end else if (hold_kick) begin
      res_ch.ready <= 1'b0;
      recv_hold <= 300;
    end else if (recv_hold > 0) begin
      res_ch.ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else if (recv_gap > 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      recv_gap <= $urandom_range(0, 11);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sprite_hits_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, res_ch.data);
        errors++;
      end else begin
        hit_want = sprite_hits_due.pop_front();
        check_field("found", 16'(hit_want.found), 16'(res_ch.data.found));
        check_field("slot", 16'(hit_want.slot), 16'(res_ch.data.slot));
        check_field("walk_step", 16'(hit_want.walk_step), 16'(res_ch.data.walk_step));
        check_field("hit_y_word", hit_want.hit_y_word, res_ch.data.hit_y_word);
        check_field("hit_x_word", hit_want.hit_x_word, res_ch.data.hit_x_word);
        check_field("hit_attr_word", hit_want.hit_attr_word, res_ch.data.hit_attr_word);
        check_field("hit_size_byte", 16'(hit_want.hit_size_byte),
                    16'(res_ch.data.hit_size_byte));
        check_field("overflow", 16'(hit_want.overflow), 16'(res_ch.data.overflow));
        check_field("last", 16'(hit_want.last), 16'(res_ch.data.last));
      end
    end
  end

  function automatic cmd_item_t rand_cmd();
    cmd_item_t c;
    c.action = 2'($urandom_range(0, 3));
    c.entry = EntryW'($urandom);
    c.y_word = 16'($urandom);
    c.size_byte = 8'($urandom);
    c.next_link = EntryW'($urandom);
    c.x_word = 16'($urandom);
    c.attr_word = 16'($urandom);
    c.scanline = 9'($urandom);
    c.vint_flag = 1'($urandom);
    return c;
  endfunction

  function automatic cmd_item_t write_a(input int ent, input logic [15:0] yw,
                                        input logic [7:0] sz, input int lnk);
    cmd_item_t c;
    c = rand_cmd();
    c.action = ActWriteA;
    c.entry = ent[EntryW-1:0];
    c.y_word = yw;
    c.size_byte = sz;
    c.next_link = lnk[EntryW-1:0];
    return c;
  endfunction

  function automatic cmd_item_t write_b(input int ent, input logic [15:0] xw,
                                        input logic [15:0] aw);
    cmd_item_t c;
    c = rand_cmd();
    c.action = ActWriteB;
    c.entry = ent[EntryW-1:0];
    c.x_word = xw;
    c.attr_word = aw;
    return c;
  endfunction

  function automatic cmd_item_t eval_cmd(input int line, input logic vint);
    cmd_item_t c;
    c = rand_cmd();
    c.action = ActEval;
    c.scanline = line[8:0];
    c.vint_flag = vint;
    return c;
  endfunction

  task automatic send(input cmd_item_t c);
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  // sender holds back until the block has drained
  task automatic wait_drained();
    do @(posedge clk);
    while (cmds_taken != cmds_queued || sprite_hits_due.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_cfg(input logic wide, input logic inter);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgWideMode;
    cfg_data <= wide;
    @(posedge clk);
    cfg_index <= CfgInterlace;
    cfg_data <= inter;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_wide = wide;
    cfg_inter = inter;
  endtask

  // one linked list built from entry 0, then several lines evaluated on it
  task automatic run_frame(input int frame, inout int items);
    int        chain[$];
    bit        used[TableEntries];
    int        len;
    int        pick;
    int        base;
    int        yp;
    int        line;
    int        lnk;
    int        n_eval;
    logic [15:0] yw;
    cmd_item_t c;
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 24);
    // keep the item count near its target
    if (len > (240 - items) / 3 + 1) len = (240 - items) / 3 + 1;
    foreach (used[k]) used[k] = 1'b0;
    used[0] = 1'b1;
    chain.push_back(0);
    while (chain.size() < len) begin
      pick = $urandom_range(1, TableEntries - 1);
      if (!used[pick]) begin
        used[pick] = 1'b1;
        chain.push_back(pick);
      end
    end
    base = $urandom_range(0, 511);
    for (int k = 0; k < len; k++) begin
      if (k < len - 1) lnk = chain[k + 1];
      else if ($urandom_range(0, 4) == 0) lnk = chain[$urandom_range(0, len - 1)];
      else lnk = 0;
      if ($urandom_range(0, 9) < 6) begin
        yp = base - int'($urandom_range(0, 35));
        if (yp < 0) yp = 0;
      end else begin
        yp = $urandom_range(0, 511);
      end
      yw = 16'($urandom);
      if (cfg_inter) yw[9:1] = yp[8:0];
      else yw[8:0] = yp[8:0];
      send(write_a(chain[k], yw, 8'($urandom), lnk));
      items++;
      if ($urandom_range(0, 9) != 0) begin
        send(write_b(chain[k], 16'($urandom), 16'($urandom)));
        items++;
      end
      if ($urandom_range(0, 15) == 0) begin
        c = rand_cmd();
        send(c);
        if (c.action != ActUnused) items++;
      end
    end
    n_eval = (frame == 1) ? 10 : $urandom_range(3, 7);
    // long hold-off on the result side while evaluations keep coming
    if (frame == 1) begin
      wait_drained();
      @(posedge clk);
      hold_kick <= 1'b1;
      @(posedge clk);
      hold_kick <= 1'b0;
    end
    for (int k = 0; k < n_eval; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        line = base + int'($urandom_range(0, 12));
        if (line > 511) line = 511;
      end else begin
        line = $urandom_range(0, 511);
      end
      send(eval_cmd(line, 1'($urandom)));
      items++;
    end
  endtask

  initial begin
    int items;
    int frame;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CfgWideMode;
    cfg_data = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    res_ch.ready = 1'b0;
    hold_kick = 1'b0;
    quiet = 1'b0;
    cmds_queued = 0;
    cmds_taken = 0;
    errors = 0;
    cfg_wide = 1'b0;
    cfg_inter = 1'b0;
    for (int k = 0; k < TableEntries; k++) begin
      y_tbl[k] = '0;
      sz_tbl[k] = '0;
      lnk_tbl[k] = '0;
      x_tbl[k] = '0;
      attr_tbl[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // cleared table: entry 0 sits at line 0 with height 8
    send(eval_cmd(0, 1'b0));
    send(eval_cmd(8, 1'b1));
    // all-ones entry at the bottom line, no wrap past line 511
    send(write_a(0, 16'hFFFF, 8'hFF, 0));
    send(write_b(0, 16'hFFFF, 16'hFFFF));
    send(eval_cmd(511, 1'b0));
    send(eval_cmd(5, 1'b0));
    send(write_a(127, 16'hFFFF, 8'hFF, 127));
    send(write_b(127, 16'h0000, 16'h0000));
    begin
      cmd_item_t c;
      c = rand_cmd();
      c.action = ActUnused;
      send(c);
    end
    send(eval_cmd(511, 1'b1));
    // two-entry loop hitting every step: hit limit with and without vint
    send(write_a(0, 16'h0100, 8'h03, 3));
    send(write_a(3, 16'h0101, 8'h02, 0));
    send(write_b(3, 16'h1234, 16'hABCD));
    send(eval_cmd(260, 1'b0));
    send(eval_cmd(260, 1'b1));
    send(eval_cmd(300, 1'b0));
    send(eval_cmd(285, 1'b0));
    // five-entry loop with one hitting entry, runs out of walk steps
    send(write_a(10, 16'h0190, 8'h00, 11));
    send(write_a(11, 16'h0190, 8'h00, 12));
    send(write_a(12, 16'h0190, 8'h00, 13));
    send(write_a(13, 16'h0040, 8'h01, 0));
    send(write_a(0, 16'h01F0, 8'h00, 10));
    send(eval_cmd(70, 1'b0));
    set_cfg(1'b1, 1'b0);
    send(eval_cmd(70, 1'b0));
    send(eval_cmd(497, 1'b0));
    set_cfg(1'b1, 1'b1);
    send(eval_cmd(40, 1'b0));
    send(eval_cmd(250, 1'b1));
    set_cfg(1'b0, 1'b1);
    send(eval_cmd(40, 1'b1));

    items = 0;
    frame = 0;
    while (items < 240) begin
      if (frame < 4) set_cfg(frame[0], frame[1]);
      else set_cfg(1'($urandom), 1'($urandom));
      if (items > 190) quiet <= 1'b1;
      run_frame(frame, items);
      frame++;
    end

    wait_drained();
    if (errors == 0 && sprite_hits_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
